// ===== design/pmat_pkg.sv =====
// ----------------------------------------------------------------------------
// pmat_pkg: shared types and constants of the priority match-action table
// Holds sizes, item codes and the queued work item passed front to back.
// ----------------------------------------------------------------------------
package pmat_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned NUM_FIELDS = 4;
  localparam int unsigned EIDX_W     = $clog2(ENTRIES);
  localparam int unsigned FIDX_W     = $clog2(NUM_FIELDS);
  localparam int unsigned CNT_W      = 5;

  typedef enum logic [1:0] {
    MODE_WR_FIELD  = 2'd0,
    MODE_WR_ACTION = 2'd1,
    MODE_LOOKUP    = 2'd2,
    MODE_RD_COUNT  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_ENTRIES = 3'd0,
    REG_FIELDS  = 3'd1,
    REG_BYTES0  = 3'd2,
    REG_BYTES1  = 3'd3,
    REG_BYTES2  = 3'd4,
    REG_BYTES3  = 3'd5
  } reg_idx_t;

  // One classified work item, as queued between front and back.
  typedef struct packed {
    mode_t       mode;
    logic        in_range;     // entry (and field) index inside the table
    logic [3:0]  entry_index;
    logic [1:0]  field_index;
    logic [63:0] write_value;
    logic        write_dontcare;
    logic [26:0] action;       // {pc, map_id, op}
    logic [63:0] key_0;
    logic [63:0] key_1;
    logic [63:0] key_2;
    logic [63:0] key_3;
  } work_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (nbytes > 4'(b)) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// ===== design/priority_match_action_table.sv =====
// ----------------------------------------------------------------------------
// priority_match_action_table: first-match ternary match-action table
// Sixteen entries of four masked key fields, one action and a hit counter each.
// ----------------------------------------------------------------------------
// A lookup compares one table entry per cycle across all active key fields,
// scanning from entry 0 and stopping at the first full match or at the last
// entry in use (entries_in_use, capped at sixteen; zero entries is a miss).
// A match passes through the hit state, which reads its action and counter
// and registers the result; an in-range count read passes through the count
// state. Field and action writes finish straight from the idle state.
// A two-deep queue decouples input acceptance from the scan engine, and one
// output register holds the result beat until popped. Hit counters clear on
// reset; entry values and actions must be written before they are looked up.
module priority_match_action_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [3:0]  entry_index,
  input  logic [1:0]  field_index,
  input  logic [63:0] write_value,
  input  logic        write_dontcare,
  input  logic [2:0]  action_op,
  input  logic [7:0]  map_id,
  input  logic [15:0] program_counter,
  input  logic [63:0] key_0,
  input  logic [63:0] key_1,
  input  logic [63:0] key_2,
  input  logic [63:0] key_3,
  output logic        empty,
  input  logic        pop,
  output logic        hit,
  output logic [3:0]  entry_number,
  output logic [2:0]  result_action,
  output logic [7:0]  result_map_id,
  output logic [15:0] result_pc,
  output logic [31:0] hit_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pmat_pkg::*;

  logic       wq_valid, wq_take, res_valid;
  work_t      wq_item;
  logic [4:0] entries_in_use;
  logic [2:0] fields_in_use;
  logic [3:0] field_bytes [4];

  // Configuration: always ready; drop writes to unknown indexes.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= 5'd0;
      fields_in_use  <= 3'd1;
      for (int i = 0; i < 4; i++) field_bytes[i] <= 4'd4;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENTRIES: entries_in_use <= cfg_data[4:0];
        REG_FIELDS:  fields_in_use  <= cfg_data[2:0];
        REG_BYTES0:  field_bytes[0] <= cfg_data[3:0];
        REG_BYTES1:  field_bytes[1] <= cfg_data[3:0];
        REG_BYTES2:  field_bytes[2] <= cfg_data[3:0];
        REG_BYTES3:  field_bytes[3] <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  pmat_front u_front (
    .clk, .rst, .push, .full, .mode, .entry_index, .field_index, .write_value,
    .write_dontcare, .action_op, .map_id, .program_counter,
    .key_0, .key_1, .key_2, .key_3, .wq_valid, .wq_item, .wq_take
  );

  pmat_back u_back (
    .clk, .rst, .wq_valid, .wq_item, .wq_take, .entries_in_use, .fields_in_use,
    .field_bytes, .res_valid, .res_take(pop && !empty), .hit, .entry_number,
    .result_action, .result_map_id, .result_pc, .hit_count
  );

  assign empty = !res_valid;

  // A popped beat leaves the output empty in the following cycle.
  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> empty)
    else $error("pop handling broken");
  // A result without a hit never reports action data.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !hit) |-> (result_action == 3'd0))
    else $error("miss carries action");
  // A full queue (two items) stays full while nothing is taken from it.
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (full && !wq_take) |=> full)
    else $error("queue lost an item");

endmodule

// ===== design/pmat_front.sv =====
// ----------------------------------------------------------------------------
// pmat_front: input stage and work queue
// Accepts items, range-checks indexes and packs them into a short queue.
// ----------------------------------------------------------------------------
module pmat_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      mode,
  input  logic [3:0]      entry_index,
  input  logic [1:0]      field_index,
  input  logic [63:0]     write_value,
  input  logic            write_dontcare,
  input  logic [2:0]      action_op,
  input  logic [7:0]      map_id,
  input  logic [15:0]     program_counter,
  input  logic [63:0]     key_0,
  input  logic [63:0]     key_1,
  input  logic [63:0]     key_2,
  input  logic [63:0]     key_3,
  output logic            wq_valid,
  output pmat_pkg::work_t wq_item,
  input  logic            wq_take
);
  import pmat_pkg::*;

  work_t      q [2];
  logic       wptr, rptr;
  logic [1:0] count;
  work_t      cur;
  logic       do_push;

  always_comb begin
    cur.mode           = mode_t'(mode);
    cur.entry_index    = entry_index;
    cur.field_index    = field_index;
    cur.in_range       = ({28'd0, entry_index} < ENTRIES) &&
                         ({30'd0, field_index} < NUM_FIELDS);
    if (mode_t'(mode) != MODE_WR_FIELD) cur.in_range = ({28'd0, entry_index} < ENTRIES);
    cur.write_value    = write_value;
    cur.write_dontcare = write_dontcare;
    cur.action         = {program_counter, map_id, action_op};
    cur.key_0          = key_0;
    cur.key_1          = key_1;
    cur.key_2          = key_2;
    cur.key_3          = key_3;
  end

  assign full     = (count == 2'd2);
  assign do_push  = push && !full;
  assign wq_valid = (count != 2'd0);
  assign wq_item  = q[rptr];

  always_ff @(posedge clk) begin
    if (do_push) q[wptr] <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (wq_take) rptr <= ~rptr;
      count <= count + {1'b0, do_push} - {1'b0, wq_take};
    end
  end

endmodule

// ===== design/pmat_back.sv =====
// ----------------------------------------------------------------------------
// pmat_back: table storage and scan engine
// Executes writes, count reads and lookups, one entry compared per cycle.
// ----------------------------------------------------------------------------
module pmat_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            wq_valid,
  input  pmat_pkg::work_t wq_item,
  output logic            wq_take,
  input  logic [4:0]      entries_in_use,
  input  logic [2:0]      fields_in_use,
  input  logic [3:0]      field_bytes [4],
  output logic            res_valid,
  input  logic            res_take,
  output logic            hit,
  output logic [3:0]      entry_number,
  output logic [2:0]      result_action,
  output logic [7:0]      result_map_id,
  output logic [15:0]     result_pc,
  output logic [31:0]     hit_count
);
  import pmat_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_HIT  = 4'b0100,
    ST_CNT  = 4'b1000
  } state_t;

  // One bank per key field: {dontcare, value}, indexed by entry.
  logic [64:0]        ent_row [NUM_FIELDS][ENTRIES];
  logic [26:0]        act_mem [ENTRIES];
  logic [31:0]        cnt_mem [ENTRIES];

  state_t             state;
  work_t              item;
  logic [EIDX_W-1:0]  scan_e;
  logic [CNT_W-1:0]   n_ent;
  logic [2:0]         n_fld;
  logic               match;
  logic [26:0]        act_q;
  logic [31:0]        cnt_q;
  logic               out_full;
  logic [63:0]        keys [4];
  logic               is_lookup;

  assign keys[0] = item.key_0;
  assign keys[1] = item.key_1;
  assign keys[2] = item.key_2;
  assign keys[3] = item.key_3;

  assign is_lookup = (wq_item.mode == MODE_LOOKUP);

  always_comb begin
    n_ent = (entries_in_use > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : entries_in_use;
    n_fld = (fields_in_use > 3'(NUM_FIELDS)) ? 3'(NUM_FIELDS) : fields_in_use;
  end

  // Compare all used fields of the current scan entry.
  always_comb begin
    logic [64:0] row;
    match = (n_fld != 3'd0);
    for (int f = 0; f < NUM_FIELDS; f++) begin
      row = ent_row[f][scan_e];
      if (3'(f) < n_fld && !row[64] &&
          (((keys[f] ^ row[63:0]) & byte_mask(field_bytes[f])) != 64'd0))
        match = 1'b0;
    end
  end

  assign wq_take = (state == ST_IDLE) && wq_valid && !out_full;
  assign res_valid = out_full;

  always_ff @(posedge clk) begin
    if (wq_take && wq_item.mode == MODE_WR_FIELD && wq_item.in_range)
      ent_row[wq_item.field_index[FIDX_W-1:0]][wq_item.entry_index[EIDX_W-1:0]] <=
        {wq_item.write_dontcare, wq_item.write_value};
    if (wq_take && wq_item.mode == MODE_WR_ACTION && wq_item.in_range)
      act_mem[wq_item.entry_index[EIDX_W-1:0]] <= wq_item.action;
    if (wq_take) item <= wq_item;
    act_q <= act_mem[scan_e];
    cnt_q <= cnt_mem[scan_e];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
      scan_e   <= '0;
      for (int e = 0; e < ENTRIES; e++) cnt_mem[e] <= '0;
    end else begin
      if (res_take) out_full <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (wq_take) begin
            hit           <= 1'b0;
            entry_number  <= is_lookup ? 4'd0 : wq_item.entry_index;
            result_action <= '0;
            result_map_id <= '0;
            result_pc     <= '0;
            hit_count     <= '0;
            scan_e        <= is_lookup ? '0 : wq_item.entry_index[EIDX_W-1:0];
            unique case (wq_item.mode)
              MODE_WR_FIELD:  out_full <= 1'b1;
              MODE_WR_ACTION: begin
                if (wq_item.in_range) cnt_mem[wq_item.entry_index[EIDX_W-1:0]] <= '0;
                out_full <= 1'b1;
              end
              MODE_RD_COUNT: begin
                if (wq_item.in_range) state <= ST_CNT;
                else out_full <= 1'b1;
              end
              MODE_LOOKUP: begin
                state <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if ({1'b0, scan_e} >= n_ent) begin
            out_full <= 1'b1;
            state    <= ST_IDLE;
          end else if (match) begin
            state <= ST_HIT;
          end else if ({1'b0, scan_e} == n_ent - CNT_W'(1)) begin
            out_full <= 1'b1;
            state    <= ST_IDLE;
          end else begin
            scan_e <= scan_e + EIDX_W'(1);
          end
        end
        ST_HIT: begin
          hit           <= 1'b1;
          entry_number  <= 4'(scan_e);
          result_action <= act_q[2:0];
          result_map_id <= act_q[10:3];
          result_pc     <= act_q[26:11];
          hit_count     <= (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
          cnt_mem[scan_e] <= (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
          out_full      <= 1'b1;
          state         <= ST_IDLE;
        end
        ST_CNT: begin
          hit_count <= cnt_mem[scan_e];
          out_full  <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
